>>> design/laser_scan_polar_to_cartesian_top_assert.svh
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_TOP_ASSERT_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_TOP_ASSERT_SVH
// ----------------------------------------------------------------------------
// Assertion helpers for the laser scan polar-to-cartesian block
// Same-cycle and next-cycle implication checks, disabled in reset.
// ----------------------------------------------------------------------------

// consequent must hold in the same cycle as the antecedent
`define LSPC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LSPC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lspc_pkg.sv
// ----------------------------------------------------------------------------
// lspc_pkg
// Shared types and constants of the laser scan polar-to-cartesian block.
// ----------------------------------------------------------------------------
`default_nettype none

package lspc_pkg;

	// register indexes (paddr[2])
	localparam logic REG_ANGLE_START = 1'b0;
	localparam logic REG_ANGLE_STEP  = 1'b1;

	// quadrant codes, quarter turns applied after the rotation chain
	localparam logic [1:0] QUAD_0   = 2'd0;
	localparam logic [1:0] QUAD_90  = 2'd1;
	localparam logic [1:0] QUAD_180 = 2'd2;
	localparam logic [1:0] QUAD_270 = 2'd3;

	localparam logic [31:0] GAIN_Q32   = 32'h9B74_EDA8; // 1/K, Q0.32
	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
	localparam int          GUARD_BITS = 16;
	localparam logic [32:0] OUT_MAX    = 33'h0_FFFF_FFFF;
	localparam logic [32:0] OUT_MIN    = 33'h1_0000_0000;

	typedef struct packed {
		logic [1:0]  quad;
		logic [15:0] intensity;
		logic        last;
	} side_t;

	// atan(2^-i) in binary turns
	function automatic logic [31:0] atan_turns(input logic [4:0] idx);
		logic [31:0] a;
		case (idx)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

>>> design/lspc_front.sv
// ----------------------------------------------------------------------------
// lspc_front
// Beam angle tracking, quadrant fold and gain-scaled start vector.
// ----------------------------------------------------------------------------
`default_nettype none
`include "laser_scan_polar_to_cartesian_top_assert.svh"

module lspc_front
	import lspc_pkg::*;
#(
	parameter int RB = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          range_value,
	input  logic [15:0]          intensity_value,
	input  logic                 intensity_present,
	input  logic                 first_of_scan,
	input  logic                 last_of_scan,
	input  logic [31:0]          angle_start,
	input  logic [31:0]          angle_step,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RB+15:0]       x_o,
	output logic signed [31:0]   z_o,
	output side_t                side_o
);

	logic              acc;
	logic [31:0]       angle;
	logic [31:0]       angle_sh;
	logic [1:0]        quad;
	logic [31:0]       res;
	logic [RB+31:0]    prod;
	logic [31:0]       beam_q;
	logic              valid_s1;
	logic [RB+15:0]    x_s1;
	logic signed [31:0] z_s1;
	side_t             side_s1;

	assign in_ready = !valid_s1 || out_ready;
	assign acc      = in_valid && in_ready;

	always_comb begin
		angle    = first_of_scan ? angle_start : beam_q + angle_step;
		angle_sh = angle + EIGHTH_TURN;
		quad     = angle_sh[31:30];
		res      = angle - {quad, 30'd0};
		prod     = (RB+32)'(range_value[RB-1:0]) * (RB+32)'(GAIN_Q32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beam_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (acc) begin
				beam_q <= angle;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1              <= prod[RB+31:GUARD_BITS];
			z_s1              <= res;
			side_s1.quad      <= quad;
			side_s1.intensity <= intensity_present ? intensity_value : 16'd0;
			side_s1.last      <= last_of_scan;
		end
	end

	assign out_valid = valid_s1;
	assign x_o       = x_s1;
	assign z_o       = z_s1;
	assign side_o    = side_s1;

	`LSPC_ASSERT_NXT(a_first_reload, clk, arst_n, acc && first_of_scan, beam_q == $past(angle_start), "beam angle not reloaded on first sample")
	`LSPC_ASSERT_NXT(a_step_advance, clk, arst_n, acc && !first_of_scan, beam_q == $past(beam_q + angle_step), "beam angle not advanced by step")
	`LSPC_ASSERT_NXT(a_angle_hold, clk, arst_n, !acc, $stable(beam_q), "beam angle moved without an item")
	`LSPC_ASSERT_IMP(a_residue_range, clk, arst_n, valid_s1, z_s1[31:29] == 3'b000 || z_s1[31:29] == 3'b111, "residue angle outside one eighth turn")

endmodule

`default_nettype wire

>>> design/lspc_cell.sv
// ----------------------------------------------------------------------------
// lspc_cell
// One CORDIC rotation cell: shift-add micro-rotation plus its register.
// ----------------------------------------------------------------------------
`default_nettype none

module lspc_cell
	import lspc_pkg::*;
#(
	parameter int W     = 51,
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic signed [31:0]  z_i,
	input  side_t               side_i,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic signed [31:0]  z_o,
	output side_t               side_o
);

	localparam logic [31:0] ATAN = atan_turns(5'(STAGE));

	logic                valid_q;
	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;
	logic signed [W-1:0] x_n;
	logic signed [W-1:0] y_n;
	logic signed [31:0]  z_n;
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [31:0]  z_q;
	side_t               side_q;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		dx = y_i >>> STAGE;
		dy = x_i >>> STAGE;
		if (!z_i[31]) begin
			x_n = x_i - dx;
			y_n = y_i + dy;
			z_n = z_i - $signed(ATAN);
		end else begin
			x_n = x_i + dx;
			y_n = y_i - dy;
			z_n = z_i + $signed(ATAN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q    <= x_n;
			y_q    <= y_n;
			z_q    <= z_n;
			side_q <= side_i;
		end
	end

	assign out_valid = valid_q;
	assign x_o       = x_q;
	assign y_o       = y_q;
	assign z_o       = z_q;
	assign side_o    = side_q;

endmodule

`default_nettype wire

>>> design/lspc_back.sv
// ----------------------------------------------------------------------------
// lspc_back
// Quarter-turn restore, rounding to Q16.16, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lspc_back
	import lspc_pkg::*;
#(
	parameter int W = 51
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  side_t               side_i,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [32:0]         point_x,
	output logic [32:0]         point_y,
	output logic [15:0]         point_intensity,
	output logic                point_last
);

	localparam int RW = W - GUARD_BITS;
	localparam int WS = (RW > 33) ? RW : 33;

	logic                 valid_q;
	logic signed [W-1:0]  xr;
	logic signed [W-1:0]  yr;
	logic signed [W-1:0]  sx;
	logic signed [W-1:0]  sy;
	logic signed [RW-1:0] rx;
	logic signed [RW-1:0] ry;
	logic [32:0]          px_n;
	logic [32:0]          py_n;
	logic [32:0]          px_q;
	logic [32:0]          py_q;
	logic [15:0]          pi_q;
	logic                 pl_q;

	function automatic logic [32:0] sat33(input logic signed [WS-1:0] v);
		logic fits;
		fits = (&v[WS-1:32]) || !(|v[WS-1:32]);
		if (fits) begin
			return v[32:0];
		end else if (v[WS-1]) begin
			return OUT_MIN;
		end
		return OUT_MAX;
	endfunction

	assign in_ready = !valid_q || !out_stall;

	always_comb begin
		case (side_i.quad)
			QUAD_90: begin
				xr = -y_i;
				yr = x_i;
			end
			QUAD_180: begin
				xr = -x_i;
				yr = -y_i;
			end
			QUAD_270: begin
				xr = y_i;
				yr = -x_i;
			end
			default: begin
				xr = x_i;
				yr = y_i;
			end
		endcase
		sx   = xr + W'(32'h0000_8000);
		sy   = yr + W'(32'h0000_8000);
		rx   = sx[W-1:GUARD_BITS];
		ry   = sy[W-1:GUARD_BITS];
		px_n = sat33(WS'(rx));
		py_n = sat33(WS'(ry));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q <= px_n;
			py_q <= py_n;
			pi_q <= side_i.intensity;
			pl_q <= side_i.last;
		end
	end

	assign out_valid       = valid_q;
	assign point_x         = px_q;
	assign point_y         = py_q;
	assign point_intensity = pi_q;
	assign point_last      = pl_q;

endmodule

`default_nettype wire

>>> design/laser_scan_polar_to_cartesian_top.sv
// ----------------------------------------------------------------------------
// laser_scan_polar_to_cartesian_top
// Laser scan sample to planar point converter, CORDIC rotation chain.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    range, intensity, flags
// out      source     out_valid / out_stall  point_x, point_y, intensity, last
// cfg      APB        psel/penable/pready    angle_start, angle_step
//
// One item per cycle while out_stall is low; the pipeline is the gain multiply
// stage, one rotation cell per CORDIC stage and the output stage.
// Reset clears all valid bits, the beam angle and both angle registers.
// Each stage holds its item while the next is full; empty stages fill in
// under a stalled output, and in_stall rises once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_polar_to_cartesian_top
	import lspc_pkg::*;
#(
	parameter int RANGE_BITS    = 32,
	parameter int CORDIC_STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] range_value,
	input  logic [15:0] intensity_value,
	input  logic        intensity_present,
	input  logic        first_of_scan,
	input  logic        last_of_scan,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [32:0] point_x,
	output logic [32:0] point_y,
	output logic [15:0] point_intensity,
	output logic        point_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RB  = (RANGE_BITS > 32) ? 32 : RANGE_BITS;
	localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int W   = RB + GUARD_BITS + 3;

	logic [31:0]         start_q;
	logic [31:0]         step_q;
	logic                front_ready;
	logic [RB+15:0]      x_front;
	logic                valid_c [0:NST];
	logic                ready_c [0:NST];
	logic signed [W-1:0] x_c     [0:NST];
	logic signed [W-1:0] y_c     [0:NST];
	logic signed [31:0]  z_c     [0:NST];
	side_t               side_c  [0:NST];

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ANGLE_STEP) ? step_q : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_ANGLE_STEP) begin
				step_q <= pwdata;
			end else begin
				start_q <= pwdata;
			end
		end
	end

	lspc_front #(
		.RB(RB)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (front_ready),
		.range_value       (range_value),
		.intensity_value   (intensity_value),
		.intensity_present (intensity_present),
		.first_of_scan     (first_of_scan),
		.last_of_scan      (last_of_scan),
		.angle_start       (start_q),
		.angle_step        (step_q),
		.out_valid         (valid_c[0]),
		.out_ready         (ready_c[0]),
		.x_o               (x_front),
		.z_o               (z_c[0]),
		.side_o            (side_c[0])
	);

	assign in_stall = !front_ready;
	assign x_c[0]   = {{(W-RB-GUARD_BITS){1'b0}}, x_front};
	assign y_c[0]   = '0;

	for (genvar i = 0; i < NST; i++) begin : g_cell
		lspc_cell #(
			.W     (W),
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.x_i       (x_c[i]),
			.y_i       (y_c[i]),
			.z_i       (z_c[i]),
			.side_i    (side_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.x_o       (x_c[i+1]),
			.y_o       (y_c[i+1]),
			.z_o       (z_c[i+1]),
			.side_o    (side_c[i+1])
		);
	end

	lspc_back #(
		.W(W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (valid_c[NST]),
		.in_ready        (ready_c[NST]),
		.x_i             (x_c[NST]),
		.y_i             (y_c[NST]),
		.side_i          (side_c[NST]),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_intensity (point_intensity),
		.point_last      (point_last)
	);

	// residual angle after the last cell is not needed
	logic unused_z;
	assign unused_z = ^z_c[NST] ^ ^paddr[1:0];

endmodule

`default_nettype wire
